[design/sht_pkg.sv]
// sht_pkg: types, codes and constants for the sensor health table
// no dependencies; imported by sht_table and the top level
package sht_pkg;

  localparam int unsigned NUM_SOURCES = 128;
  localparam int unsigned SRC_W       = 8;
  localparam int unsigned SRC_IDX_W   = 7;
  localparam int unsigned INJECT_BIT  = 7;

  localparam logic [1:0] OP_REPORT  = 2'd0;
  localparam logic [1:0] OP_RESTORE = 2'd1;
  localparam logic [1:0] OP_QUERY   = 2'd2;

  localparam logic [1:0] ST_NOMINAL  = 2'd0;
  localparam logic [1:0] ST_DEGRADED = 2'd1;
  localparam logic [1:0] ST_FAILED   = 2'd2;

  typedef struct packed {
    logic [1:0]       operation;
    logic [SRC_W-1:0] source;
    logic [1:0]       status;
  } item_t;

  typedef struct packed {
    logic any_degraded;
    logic any_failed;
    logic inject_error;
  } result_t;

  typedef struct packed {
    logic  fire;
    item_t item;
  } upd_t;

endpackage

[design/sht_table.sv]
// sht_table: per-source known, real, shown and override state with update logic
// and flag reduction over the next state; depends on sht_pkg
module sht_table #(
  parameter int unsigned NumSources = sht_pkg::NUM_SOURCES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sht_pkg::upd_t    upd_i,
  output sht_pkg::result_t res_o
);
  import sht_pkg::*;

  localparam int unsigned IdxW = $clog2(NumSources);
  localparam logic [SRC_IDX_W:0] SrcLimit = NumSources[SRC_IDX_W:0];

  logic [SRC_IDX_W-1:0]  idx;
  logic [IdxW-1:0]       sel_idx;
  logic                  in_range;
  logic                  is_inject;
  logic                  hit_known;
  logic [NumSources-1:0] known_v;
  logic [NumSources-1:0] deg_v;
  logic [NumSources-1:0] fail_v;

  assign idx       = upd_i.item.source[SRC_IDX_W-1:0];
  assign sel_idx   = idx[IdxW-1:0];
  assign in_range  = {1'b0, idx} < SrcLimit;
  assign is_inject = upd_i.item.source[INJECT_BIT];
  assign hit_known = in_range && known_v[sel_idx];

  for (genvar i = 0; i < NumSources; i++) begin : g_entry
    logic       known_q, known_d;
    logic       ovr_q, ovr_d;
    logic [1:0] real_q, real_d;
    logic [1:0] shown_q, shown_d;
    logic       hit;

    assign hit = in_range && (sel_idx == IdxW'(i));

    always_comb begin
      known_d = known_q;
      ovr_d   = ovr_q;
      real_d  = real_q;
      shown_d = shown_q;
      if (upd_i.fire) begin
        case (upd_i.item.operation)
          OP_REPORT: begin
            if (is_inject) begin
              if (hit && known_q) begin
                shown_d = upd_i.item.status;
                ovr_d   = 1'b1;
              end
            end else if (hit) begin
              known_d = 1'b1;
              ovr_d   = known_q ? ovr_q : 1'b0;
              real_d  = upd_i.item.status;
              if (!ovr_d) begin
                shown_d = upd_i.item.status;
              end
            end
          end
          OP_RESTORE: begin
            shown_d = real_q;
            ovr_d   = 1'b0;
          end
          default: begin
          end
        endcase
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        known_q <= 1'b0;
        ovr_q   <= 1'b0;
        real_q  <= ST_NOMINAL;
        shown_q <= ST_NOMINAL;
      end else begin
        known_q <= known_d;
        ovr_q   <= ovr_d;
        real_q  <= real_d;
        shown_q <= shown_d;
      end
    end

    assign known_v[i] = known_q;
    assign deg_v[i]   = known_d && (shown_d == ST_DEGRADED);
    assign fail_v[i]  = known_d && (shown_d == ST_FAILED);
  end

  assign res_o.any_degraded = |deg_v;
  assign res_o.any_failed   = |fail_v;
  assign res_o.inject_error = (upd_i.item.operation == OP_REPORT) && is_inject && !hit_known;

endmodule

[design/sensor_health_table_with_injection.sv]
// sensor_health_table_with_injection: top level with input and result registers
// around the health table; depends on sht_pkg and sht_table
//
//   channel  direction  handshake                  payload
//   in       in         in_valid_i / in_stall_o    in_item_i  (sht_pkg::item_t)
//   out      out        out_valid_o / out_stall_i  out_item_o (sht_pkg::result_t)
//
// one item per cycle unless a result is stalled; items and results are both registered
// the table update and the flag reduction sit between the input and result registers
// reset clears all entries at once, no clearing pass
// a stalled result holds the input register, which stalls the input channel
module sensor_health_table_with_injection #(
  parameter int unsigned NumSources = sht_pkg::NUM_SOURCES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sht_pkg::item_t   in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sht_pkg::result_t out_item_o
);
  import sht_pkg::*;

  logic    in_valid_q, in_valid_d;
  item_t   in_q;
  logic    out_valid_q, out_valid_d;
  result_t out_q;
  logic    advance;
  logic    fire;
  upd_t    upd;
  result_t res_d;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  assign upd.fire = fire;
  assign upd.item = in_q;

  sht_table #(
    .NumSources(NumSources)
  ) u_table (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .upd_i (upd),
    .res_o (res_d)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_valid_i && !in_stall_o) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
    if (fire) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  a_stall_only_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("processed item produced no result");

  a_error_only_on_inject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (in_q.operation != OP_REPORT || !in_q.source[INJECT_BIT])) |-> !res_d.inject_error)
    else $error("inject error on an item that is not an injection");

  a_result_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !fire) |=> !out_valid_q)
    else $error("taken result not retired");

endmodule
